// File: rtl/core/comvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// comvc_pkg
// Shared constants and types for the center-of-mass velocity contact block.
// ----------------------------------------------------------------------------
package comvc_pkg;

    localparam int MaxFields = 8;
    localparam int FieldIdxW = $clog2(MaxFields);
    localparam int CountW    = FieldIdxW + 1;
    localparam int StoreDepth = MaxFields * 3;
    localparam int StoreAw   = $clog2(StoreDepth);

    localparam logic [0:0] RegMode = 1'd0;
    localparam logic [0:0] RegInvTs = 1'd1;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend_mag;
        logic [39:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage : comvc_pkg
`default_nettype wire

// File: rtl/core/comvc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// comvc_divider
// Restoring radix-2 unsigned divider, 64-bit dividend by 40-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module comvc_divider (
    input  wire                aclk,
    input  wire                aresetn,
    input  comvc_pkg::div_req_t req,
    output comvc_pkg::div_rsp_t rsp
);

    logic [63:0] quo_reg;
    logic [39:0] rem_reg;
    logic [39:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [40:0] trial;
    logic [40:0] diff;

    // trial < 2 * divisor, so the difference fits 41 bits with its sign on top
    always_comb begin
        trial = {rem_reg, quo_reg[63]};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                quo_reg  <= req.dividend_mag;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
                cnt_reg  <= 7'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[40]) begin
                    rem_reg <= diff[39:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= trial[39:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule : comvc_divider
`default_nettype wire

// File: rtl/core/center_of_mass_velocity_contact.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// center_of_mass_velocity_contact
// Single-velocity contact for one grid node: center-of-mass velocity update.
// ----------------------------------------------------------------------------
// Each field of a node is one input transaction; the 32x31 momentum multiply
// and the accumulate follow one another per axis (product register, then
// momentum register). When the node's mass sum is nonzero, the closing
// field adds, per axis, a bit-serial divide of the momentum magnitude by the
// mass sum (launch, quotient steps, capture); then one result per field:
// per axis a read, a multiply and an update on the shared multiplier, then
// a packing state and the output handshake.
// The block is not ready while a node is being resolved or emitted.
module center_of_mass_velocity_contact (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // mass[30:0], vel_x[62:31], vel_y, vel_z, acc_x, acc_y, acc_z, zero pad
    input  wire  [223:0] s_tdata,
    input  wire          s_tlast,
    output logic         m_tvalid,
    input  wire          m_tready,
    // field_index[2:0], new_vel_x[34:3], new_vel_y, new_vel_z, new_acc_x,
    // new_acc_y, new_acc_z, zero pad
    output logic [199:0] m_tdata,
    output logic         m_tlast,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [0:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MAC   = 9'b000000010,
        S_DIVGO = 9'b000000100,
        S_DIVWT = 9'b000001000,
        S_RDST  = 9'b000010000,
        S_ADJ   = 9'b000100000,
        S_ADJW  = 9'b001000000,
        S_PACK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    logic        mode_reg;
    logic [31:0] its_reg;

    logic [63:0] store_mem [comvc_pkg::StoreDepth];
    logic [63:0] rd_reg;

    logic [30:0] mass_in_reg;
    logic [31:0] vel_in_reg [3];
    logic [31:0] acc_in_reg [3];
    logic        last_in_reg;

    logic signed [63:0] mom_reg [3];
    logic [39:0] msum_reg;
    logic [comvc_pkg::CountW-1:0] cnt_reg;
    logic [comvc_pkg::FieldIdxW-1:0] slot_reg;
    logic [1:0]  ax_reg;
    logic [comvc_pkg::FieldIdxW-1:0] k_reg;
    logic signed [31:0] vcm_reg [3];
    logic [31:0] nvel_reg [3];
    logic [31:0] nacc_reg [3];
    logic signed [65:0] prod_reg;

    // shared multiplier: 33-bit signed x 33-bit signed
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    comvc_pkg::div_req_t div_req;
    comvc_pkg::div_rsp_t div_rsp;

    comvc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic signed [63:0] cur_mom;
    logic        mom_neg;
    logic [63:0] mom_mag;
    logic signed [31:0] v_rd, a_rd;
    logic signed [32:0] dv;
    logic signed [64:0] sum65;
    logic signed [65:0] delta;
    logic signed [65:0] acc_sum;
    logic signed [31:0] vcm_sat;
    logic [63:0] q;
    logic [comvc_pkg::StoreAw-1:0] wr_addr, rd_addr;

    always_comb begin
        cur_mom = mom_reg[ax_reg];
        mom_neg = cur_mom[63];
        mom_mag = mom_neg ? (~cur_mom + 64'd1) : cur_mom;
        div_req.start        = (state_reg == S_DIVGO);
        div_req.dividend_mag = mom_mag;
        div_req.divisor      = msum_reg;
        q = div_rsp.quotient;
        if (mom_neg)
            vcm_sat = (q > 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
        else
            vcm_sat = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];

        v_rd = rd_reg[31:0];
        a_rd = rd_reg[63:32];
        dv   = {vcm_reg[ax_reg][31], vcm_reg[ax_reg]} - {v_rd[31], v_rd};
        if (state_reg == S_MAC) begin
            mul_a = {vel_in_reg[ax_reg][31], vel_in_reg[ax_reg]};
            mul_b = {2'b0, mass_in_reg};
        end else begin
            mul_a = dv;
            mul_b = {1'b0, its_reg};
        end

        sum65 = {mom_reg[ax_reg][63], mom_reg[ax_reg]} + prod_reg[64:0];
        // toward-zero shift of the signed product
        delta = prod_reg[65] ? -((-prod_reg) >>> 16) : (prod_reg >>> 16);
        acc_sum = {{34{a_rd[31]}}, a_rd} + delta;

        wr_addr = comvc_pkg::StoreAw'(slot_reg * 3 + ax_reg);
        rd_addr = comvc_pkg::StoreAw'(k_reg * 3 + ax_reg);
    end

    logic prod_vld_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_RDST)
            rd_reg <= store_mem[rd_addr];
        if (state_reg == S_MAC && !prod_vld_reg)
            store_mem[wr_addr] <= {acc_in_reg[ax_reg], vel_in_reg[ax_reg]};
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b0;
            its_reg      <= 32'h0001_0000;
            msum_reg     <= '0;
            cnt_reg      <= '0;
            ax_reg       <= '0;
            k_reg        <= '0;
            prod_vld_reg <= 1'b0;
            for (int i = 0; i < 3; i++) mom_reg[i] <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    comvc_pkg::RegMode:  mode_reg <= cfg_data[0];
                    comvc_pkg::RegInvTs: its_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mass_in_reg <= s_tdata[30:0];
                        for (int i = 0; i < 3; i++) begin
                            vel_in_reg[i] <= s_tdata[31 + 32*i +: 32];
                            acc_in_reg[i] <= s_tdata[127 + 32*i +: 32];
                        end
                        last_in_reg <= s_tlast;
                        slot_reg <= (cnt_reg >= comvc_pkg::CountW'(comvc_pkg::MaxFields))
                            ? comvc_pkg::FieldIdxW'(comvc_pkg::MaxFields - 1)
                            : cnt_reg[comvc_pkg::FieldIdxW-1:0];
                        ax_reg <= '0;
                        prod_vld_reg <= 1'b0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (!prod_vld_reg) begin
                        prod_reg <= mul_p;
                        prod_vld_reg <= 1'b1;
                    end else begin
                        prod_vld_reg <= 1'b0;
                        if (sum65[64] != sum65[63])
                            mom_reg[ax_reg] <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        else
                            mom_reg[ax_reg] <= sum65[63:0];
                        if (ax_reg == 2'd2) begin
                            logic [comvc_pkg::CountW-1:0] nc;
                            nc = comvc_pkg::CountW'(slot_reg) + 1'b1;
                            msum_reg <= msum_reg + 40'(mass_in_reg);
                            cnt_reg  <= nc;
                            ax_reg   <= '0;
                            if (last_in_reg ||
                                nc >= comvc_pkg::CountW'(comvc_pkg::MaxFields)) begin
                                state_reg <= ((msum_reg + 40'(mass_in_reg)) != 40'd0)
                                    ? S_DIVGO : S_RDST;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                            k_reg <= '0;
                        end else begin
                            ax_reg <= ax_reg + 2'd1;
                        end
                    end
                end
                S_DIVGO: state_reg <= S_DIVWT;
                S_DIVWT: begin
                    if (div_rsp.done) begin
                        vcm_reg[ax_reg] <= vcm_sat;
                        if (ax_reg == 2'd2) begin
                            ax_reg <= '0;
                            state_reg <= S_RDST;
                        end else begin
                            ax_reg <= ax_reg + 2'd1;
                            state_reg <= S_DIVGO;
                        end
                    end
                end
                S_RDST: state_reg <= S_ADJ;
                S_ADJ: begin
                    prod_reg <= mul_p;
                    state_reg <= S_ADJW;
                end
                S_ADJW: begin
                    if (msum_reg != 40'd0) begin
                        nvel_reg[ax_reg] <= vcm_reg[ax_reg];
                        if (mode_reg) begin
                            if (acc_sum > 66'sh7FFF_FFFF)
                                nacc_reg[ax_reg] <= 32'h7FFF_FFFF;
                            else if (acc_sum < -66'sh8000_0000)
                                nacc_reg[ax_reg] <= 32'h8000_0000;
                            else
                                nacc_reg[ax_reg] <= acc_sum[31:0];
                        end else begin
                            nacc_reg[ax_reg] <= a_rd;
                        end
                    end else begin
                        nvel_reg[ax_reg] <= v_rd;
                        nacc_reg[ax_reg] <= a_rd;
                    end
                    if (ax_reg == 2'd2) begin
                        ax_reg <= '0;
                        state_reg <= S_PACK;
                    end else begin
                        ax_reg <= ax_reg + 2'd1;
                        state_reg <= S_RDST;
                    end
                end
                S_PACK: state_reg <= S_OUT;
                S_OUT: begin
                    if (m_tready) begin
                        if (comvc_pkg::CountW'(k_reg) + 1'b1 == cnt_reg) begin
                            for (int i = 0; i < 3; i++) mom_reg[i] <= '0;
                            msum_reg <= '0;
                            cnt_reg  <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_RDST;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[2:0] = 3'(k_reg);
        for (int i = 0; i < 3; i++) begin
            m_tdata[3 + 32*i +: 32]  = nvel_reg[i];
            m_tdata[99 + 32*i +: 32] = nacc_reg[i];
        end
        m_tlast = (comvc_pkg::CountW'(k_reg) + 1'b1 == cnt_reg);
    end

endmodule : center_of_mass_velocity_contact
`default_nettype wire

// File: tb/center_of_mass_velocity_contact_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_of_mass_velocity_contact_tb
// Streams grid-node fields through the contact block and compares every
// result against a bit-accurate predictor of the center-of-mass velocity and
// acceleration update, across both modes and several time-step settings.
// ----------------------------------------------------------------------------
module center_of_mass_velocity_contact_tb;

    typedef struct {
        logic [30:0] mass;
        logic signed [31:0] vel [3];
        logic signed [31:0] acc [3];
        logic        last;
    } field_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] vel [3];
        logic [31:0] acc [3];
        logic        last;
    } node_out_t;

    class contact_scoreboard;
        bit          integrated;
        logic [31:0] inv_ts;
        logic signed [31:0] st_vel [comvc_pkg::MaxFields][3];
        logic signed [31:0] st_acc [comvc_pkg::MaxFields][3];
        longint      mom [3];
        logic [39:0] msum;
        int          cnt;
        node_out_t   pending [$];
        int          errors;

        function new();
            integrated = 0;
            inv_ts = 32'd65536;
            msum = 0;
            cnt = 0;
            errors = 0;
            for (int a = 0; a < 3; a++) mom[a] = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint sat_add(longint s, longint p);
            longint r;
            r = s + p;
            if (p > 0 && r < s) return 64'h7fffffffffffffff;
            if (p < 0 && r > s) return 64'h8000000000000000;
            return r;
        endfunction

        function logic [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint vcm_of(longint m);
            logic [63:0] q;
            q = mag(m) / {24'd0, msum};
            if (m < 0) return q > 64'h80000000 ? -64'sd2147483648 : -longint'(q);
            return q > 64'h7fffffff ? 64'sd2147483647 : longint'(q);
        endfunction

        function longint adj(longint acc, longint vc, longint v);
            longint d;
            logic [63:0] p;
            d = vc - v;
            p = (mag(d) * {32'd0, inv_ts}) >> 16;
            return sat32(d < 0 ? acc - longint'(p) : acc + longint'(p));
        endfunction

        function void note_field(field_t it);
            int f;
            longint vc [3];
            node_out_t o;
            f = cnt >= comvc_pkg::MaxFields ? comvc_pkg::MaxFields - 1 : cnt;
            for (int a = 0; a < 3; a++) begin
                st_vel[f][a] = it.vel[a];
                st_acc[f][a] = it.acc[a];
                mom[a] = sat_add(mom[a], longint'(it.vel[a]) * longint'({1'b0, it.mass}));
            end
            msum = msum + {9'd0, it.mass};
            cnt = f + 1;
            if (!it.last && cnt < comvc_pkg::MaxFields) return;
            for (int a = 0; a < 3; a++) vc[a] = msum != 0 ? vcm_of(mom[a]) : 0;
            for (int k = 0; k < cnt; k++) begin
                o.idx = 3'(k);
                for (int a = 0; a < 3; a++) begin
                    o.vel[a] = st_vel[k][a];
                    o.acc[a] = st_acc[k][a];
                    if (msum != 0) begin
                        o.vel[a] = 32'(vc[a]);
                        if (integrated)
                            o.acc[a] = 32'(adj(st_acc[k][a], vc[a], st_vel[k][a]));
                    end
                end
                o.last = (k + 1 == cnt);
                pending.push_back(o);
            end
            for (int a = 0; a < 3; a++) mom[a] = 0;
            msum = 0;
            cnt = 0;
        endfunction

        function void check_result(logic [199:0] d, logic l);
            node_out_t e;
            logic [199:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, d, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            want = {5'd0, e.acc[2], e.acc[1], e.acc[0], e.vel[2], e.vel[1], e.vel[0], e.idx};
            if (d !== want || l !== e.last) begin
                $display("%0t: mismatch expected %h last %b, actual %h last %b",
                         $time, want, e.last, d, l);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    contact_scoreboard sb;
    int burst_left;

    center_of_mass_velocity_contact u_dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // receiver stalls on a rotating pattern, with recurring stretches of no stalls
    int rx_cyc;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_cyc <= 0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            if ((rx_cyc / 3000) % 3 == 1) m_tready <= 1'b1;
            else m_tready <= ((rx_cyc % 7) < 4) || ($urandom_range(0, 3) == 0);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    function logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 8'hff)) - 128) << 16;
            default: return $urandom;
        endcase
    endfunction

    // tvalid is dropped after each accepted field before it is raised again, so fields never go back to back
    task automatic send_field(field_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end else begin
            @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tlast <= it.last;
        s_tdata <= {1'b0, it.acc[2], it.acc[1], it.acc[0],
                    it.vel[2], it.vel[1], it.vel[0], it.mass};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_field(it);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_node(int n, int mass_kind);
        field_t it;
        for (int i = 0; i < n; i++) begin
            case (mass_kind)
                0: it.mass = 31'd0;
                1: it.mass = 31'h7fffffff;
                2: it.mass = 31'($urandom_range(0, 32'h000fffff));
                default: it.mass = 31'($urandom);
            endcase
            for (int a = 0; a < 3; a++) begin
                it.vel[a] = rnd_val();
                it.acc[a] = rnd_val();
            end
            it.last = (i == n - 1);
            send_field(it);
        end
    endtask

    task automatic drain_and_write(logic [0:0] idx, logic [31:0] val);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == comvc_pkg::RegMode) sb.integrated = val[0];
        else sb.inv_ts = val;
    endtask

    task automatic random_nodes(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(1, comvc_pkg::MaxFields + 2);
            // beyond MaxFields the node closes early and the extra items start a new one
            send_node(n, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
            sent += n;
        end
        send_node(1, 3);
    endtask

    initial begin
        field_t it;
        sb = new();
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single field, zero mass, full mass, overflowing node
        send_node(1, 1);
        send_node(2, 0);
        send_node(3, 1);
        send_node(comvc_pkg::MaxFields + 1, 2);
        it.mass = 31'h7fffffff;
        for (int a = 0; a < 3; a++) begin
            it.vel[a] = 32'h80000000;
            it.acc[a] = 32'h7fffffff;
        end
        it.last = 1'b0;
        send_field(it);
        it.mass = 31'd1;
        for (int a = 0; a < 3; a++) begin
            it.vel[a] = 32'h7fffffff;
            it.acc[a] = 32'h80000000;
        end
        it.last = 1'b1;
        send_field(it);

        drain_and_write(comvc_pkg::RegMode, 32'd1);
        send_node(2, 1);
        send_node(3, 3);
        random_nodes(50);
        drain_and_write(comvc_pkg::RegInvTs, 32'hffffffff);
        send_node(2, 1);
        random_nodes(45);
        drain_and_write(comvc_pkg::RegInvTs, 32'd0);
        random_nodes(30);
        drain_and_write(comvc_pkg::RegInvTs, $urandom);
        random_nodes(35);
        drain_and_write(comvc_pkg::RegMode, 32'd0);
        random_nodes(25);

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
